// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- sv/bps_pkg.sv -----
package bps_pkg;

  typedef enum logic [1:0] {
    CMD_BEEP   = 2'd0,
    CMD_OFF    = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_SAFETY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_MAX_PULSE    = 2'd0,
    CFG_GAP          = 2'd1,
    CFG_SAFETY_LIMIT = 2'd2
  } cfg_idx_t;

  localparam logic [2:0] PAT_SILENT = 3'd0;
  localparam logic [2:0] PAT_SHORT  = 3'd1;
  localparam logic [2:0] PAT_TRIPLE = 3'd2;
  localparam logic [2:0] PAT_URGENT = 3'd3;
  localparam logic [2:0] PAT_LONG   = 3'd4;

  localparam logic [15:0] MAX_PULSE_RESET    = 16'd300;
  localparam logic [15:0] GAP_RESET          = 16'd80;
  localparam logic [31:0] SAFETY_LIMIT_RESET = 32'd2000;

  localparam int unsigned MID_DEPTH_DEFAULT = 4;
  localparam int unsigned OUT_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [15:0] max_pulse_ms;
    logic [15:0] gap_ms;
    logic [31:0] safety_limit_ms;
  } cfg_t;

  // Classified command word, front to back.
  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  pattern;
    logic [31:0] beep_ms;
    logic [31:0] now_ms;
    logic [2:0]  beep_count;
    logic [15:0] on_duration;
  } cmd_word_t;

  typedef struct packed {
    logic        drive_write;
    logic        drive_level;
    logic        sounding_phase;
    logic        busy_res;
    logic [31:0] safety_cut_count;
  } res_word_t;

  function automatic logic [2:0] beeps_of(input logic [2:0] pat);
    logic [2:0] n;
    unique case (pat)
      PAT_SHORT:  n = 3'd1;
      PAT_TRIPLE: n = 3'd3;
      PAT_URGENT: n = 3'd4;
      PAT_LONG:   n = 3'd3;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] clamp_on(input logic [31:0] ms, input logic [15:0] max_p);
    logic [15:0] hi;
    logic [15:0] r;
    hi = (max_p == 16'd0) ? 16'd1 : max_p;
    if (ms == 32'd0) begin
      r = 16'd1;
    end else if (ms > {16'd0, hi}) begin
      r = hi;
    end else begin
      r = ms[15:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/beep_pattern_sequencer_unit.sv -----
// Beep pattern sequencer for an active buzzer. Commands (beep, off, tick,
// safety check) are pushed as words and every word yields exactly one result
// word, in order. The front stage decodes the pattern and clamps the on time,
// a MID_DEPTH queue decouples it from the back stage, which updates the
// sequence state once per cycle while a word waits and the result queue is
// not full, and writes an OUT_DEPTH result queue. One word per cycle is
// sustained as long as results are popped; a word passes from the mid queue
// through the back stage's update into the result queue, from which it is
// popped. Configuration writes are taken at any time but are meant for when
// both queues are empty.
module beep_pattern_sequencer_unit import bps_pkg::*; #(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [2:0]  pattern,
  input  logic [31:0] beep_ms,
  input  logic [31:0] now_ms,
  output logic        empty,
  input  logic        pop,
  output logic        drive_write,
  output logic        drive_level,
  output logic        sounding_phase,
  output logic        busy_res,
  output logic [31:0] safety_cut_count
);

  cfg_t      cfg;
  cmd_word_t front_word;
  cmd_word_t mid_word;
  res_word_t back_word;
  res_word_t res_word;
  logic      front_push;
  logic      mid_full;
  logic      mid_empty;
  logic      mid_pop;
  logic      out_push;
  logic      out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_pulse_ms    <= MAX_PULSE_RESET;
      cfg.gap_ms          <= GAP_RESET;
      cfg.safety_limit_ms <= SAFETY_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_PULSE:    cfg.max_pulse_ms    <= cfg_data[15:0];
        CFG_GAP:          cfg.gap_ms          <= cfg_data[15:0];
        CFG_SAFETY_LIMIT: cfg.safety_limit_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  bps_front u_front (
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .pattern      (pattern),
    .beep_ms      (beep_ms),
    .now_ms       (now_ms),
    .max_pulse_ms (cfg.max_pulse_ms),
    .q_full       (mid_full),
    .q_push       (front_push),
    .q_word       (front_word)
  );

  bps_fifo #(.T(cmd_word_t), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_word),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_word),
    .empty (mid_empty)
  );

  bps_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_word          (mid_word),
    .q_empty         (mid_empty),
    .q_pop           (mid_pop),
    .out_full        (out_full),
    .out_push        (out_push),
    .out_word        (back_word),
    .gap_ms          (cfg.gap_ms),
    .safety_limit_ms (cfg.safety_limit_ms)
  );

  bps_fifo #(.T(res_word_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (back_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_word),
    .empty (empty)
  );

  assign drive_write      = res_word.drive_write;
  assign drive_level      = res_word.drive_level;
  assign sounding_phase   = res_word.sounding_phase;
  assign busy_res         = res_word.busy_res;
  assign safety_cut_count = res_word.safety_cut_count;

endmodule

// ----- sv/bps_fifo.sv -----
module bps_fifo import bps_pkg::*; #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wrap_inc(wptr);
      if (do_pop)  rptr <= wrap_inc(rptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/bps_front.sv -----
module bps_front import bps_pkg::*; (
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [2:0]  pattern,
  input  logic [31:0] beep_ms,
  input  logic [31:0] now_ms,
  input  logic [15:0] max_pulse_ms,
  input  logic        q_full,
  output logic        q_push,
  output cmd_word_t   q_word
);

  assign full   = q_full;
  assign q_push = push;

  // pattern lookup and on-time clamp happen here, off the back's state loop
  always_comb begin
    q_word.cmd         = cmd_t'(cmd);
    q_word.pattern     = pattern;
    q_word.beep_ms     = beep_ms;
    q_word.now_ms      = now_ms;
    q_word.beep_count  = beeps_of(pattern);
    q_word.on_duration = clamp_on(beep_ms, max_pulse_ms);
  end

endmodule

// ----- sv/bps_back.sv -----
module bps_back import bps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_word_t   q_word,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        out_full,
  output logic        out_push,
  output res_word_t   out_word,
  input  logic [15:0] gap_ms,
  input  logic [31:0] safety_limit_ms
);

  logic        seq_active, seq_active_next;
  logic [2:0]  beep_count, beep_count_next;
  logic [15:0] on_duration, on_duration_next;
  logic [3:0]  phase_index, phase_index_next;
  logic [31:0] phase_start, phase_start_next;
  logic [31:0] sequence_start, sequence_start_next;
  logic [2:0]  last_pattern, last_pattern_next;
  logic [31:0] last_request_ms, last_request_ms_next;
  logic        level_on, level_on_next;
  logic [31:0] cut_counter, cut_counter_next;

  logic        step;

  assign step     = !q_empty && !out_full;
  assign q_pop    = step;
  assign out_push = step;

  always_comb begin
    logic        is_on;
    logic [15:0] dur;
    logic [31:0] ps;
    logic [31:0] elapsed;
    logic [3:0]  pi_inc;
    logic        clr;

    seq_active_next      = seq_active;
    beep_count_next      = beep_count;
    on_duration_next     = on_duration;
    phase_index_next     = phase_index;
    phase_start_next     = phase_start;
    sequence_start_next  = sequence_start;
    last_pattern_next    = last_pattern;
    last_request_ms_next = last_request_ms;
    level_on_next        = level_on;
    cut_counter_next     = cut_counter;
    clr                  = 1'b0;

    is_on   = phase_index[0];
    dur     = is_on ? on_duration : ((beep_count > 3'd1) ? gap_ms : 16'd0);
    ps      = (q_word.now_ms - phase_start) >> 31 != 32'd0 ? q_word.now_ms : phase_start;
    elapsed = q_word.now_ms - ps;
    pi_inc  = phase_index + 4'd1;

    unique case (q_word.cmd)
      CMD_BEEP: begin
        if (!(seq_active && q_word.pattern == last_pattern
              && q_word.beep_ms == last_request_ms)) begin
          last_pattern_next    = q_word.pattern;
          last_request_ms_next = q_word.beep_ms;
          beep_count_next      = q_word.beep_count;
          on_duration_next     = q_word.on_duration;
          phase_index_next     = 4'd0;
          seq_active_next      = (q_word.beep_count != 3'd0);
          phase_start_next     = q_word.now_ms;
          sequence_start_next  = q_word.now_ms;
          level_on_next        = 1'b0;
        end
      end
      CMD_OFF: begin
        clr           = 1'b1;
        level_on_next = 1'b0;
      end
      CMD_TICK: begin
        if (seq_active) begin
          if (phase_index == 4'd0) begin
            if (beep_count == 3'd0) begin
              clr = 1'b1;
            end else begin
              level_on_next    = 1'b1;
              phase_index_next = 4'd1;
              phase_start_next = q_word.now_ms;
            end
          end else begin
            phase_start_next = ps;
            if ({16'd0, dur} <= elapsed) begin
              if (is_on) begin
                level_on_next    = 1'b0;
                phase_index_next = pi_inc;
                if ({1'b0, pi_inc[3:1]} >= {1'b0, beep_count}) begin
                  clr = 1'b1;
                end else begin
                  phase_start_next = q_word.now_ms;
                end
              end else if ({1'b0, phase_index[3:1]} < {1'b0, beep_count}) begin
                level_on_next    = 1'b1;
                phase_index_next = pi_inc;
                phase_start_next = q_word.now_ms;
              end else begin
                clr              = 1'b1;
                phase_start_next = q_word.now_ms;
                level_on_next    = 1'b0;
              end
            end
          end
        end
      end
      CMD_SAFETY: begin
        if (seq_active && (q_word.now_ms - sequence_start) >= safety_limit_ms) begin
          cut_counter_next = cut_counter + 32'd1;
          clr              = 1'b1;
          level_on_next    = 1'b0;
        end
      end
      default: ;
    endcase

    if (clr) begin
      seq_active_next      = 1'b0;
      phase_index_next     = 4'd0;
      beep_count_next      = 3'd0;
      last_pattern_next    = PAT_SILENT;
      last_request_ms_next = 32'd0;
    end

    out_word.drive_write      = (level_on_next != level_on);
    out_word.drive_level      = level_on_next;
    out_word.sounding_phase   = seq_active_next && phase_index_next[0];
    out_word.busy_res         = seq_active_next;
    out_word.safety_cut_count = cut_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active      <= 1'b0;
      beep_count      <= 3'd0;
      on_duration     <= 16'd0;
      phase_index     <= 4'd0;
      phase_start     <= 32'd0;
      sequence_start  <= 32'd0;
      last_pattern    <= PAT_SILENT;
      last_request_ms <= 32'd0;
      level_on        <= 1'b0;
      cut_counter     <= 32'd0;
    end else if (step) begin
      seq_active      <= seq_active_next;
      beep_count      <= beep_count_next;
      on_duration     <= on_duration_next;
      phase_index     <= phase_index_next;
      phase_start     <= phase_start_next;
      sequence_start  <= sequence_start_next;
      last_pattern    <= last_pattern_next;
      last_request_ms <= last_request_ms_next;
      level_on        <= level_on_next;
      cut_counter     <= cut_counter_next;
    end
  end

endmodule

// ----- sv/bps_checker.sv -----
`include "assert_macros.svh"

module bps_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        drive_write,
  input logic        drive_level,
  input logic        sounding_phase,
  input logic        busy_res,
  input logic [31:0] safety_cut_count
);

  logic        last_level;
  logic [31:0] last_cut;
  logic        take;

  assign take = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
      last_cut   <= 32'd0;
    end else if (take) begin
      last_level <= drive_level;
      last_cut   <= safety_cut_count;
    end
  end

  `ASSERT_CLK(a_reset_drains, clk, rst |=> (empty && !full))
  `ASSERT_CLK_RST(a_write_on_change, clk, rst,
    take |-> (drive_write == (drive_level != last_level)))
  `ASSERT_CLK_RST(a_sounding_is_on, clk, rst,
    (!empty && sounding_phase) |-> (busy_res && drive_level))
  `ASSERT_CLK_RST(a_cut_steps, clk, rst,
    take |-> (safety_cut_count == last_cut || safety_cut_count == last_cut + 32'd1))

endmodule

bind beep_pattern_sequencer_unit bps_checker u_bps_checker (.*);
